[src/bpdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc_pkg
// Shared types and constants for the de Casteljau Bezier point evaluator.
// ----------------------------------------------------------------------------
package bpdc_pkg;

  localparam int MAX_POINTS = 16;
  localparam int COORD_W    = 32;
  localparam int T_W        = 17;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam logic [T_W-1:0] T_ONE = T_W'(65536);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;
  localparam logic [1:0] CMD_IGNORE = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0]          idx_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [T_W-1:0]     t_param;
  } bpdc_in_t;

  typedef struct packed {
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;
    logic [1:0]         status;
  } bpdc_out_t;

  typedef struct packed {
    logic ctrl_we;
    idx_t ctrl_waddr;
    idx_t ctrl_raddr;
    logic work_we;
    idx_t work_waddr;
    idx_t work_raddr;
  } bpdc_mem_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_DRAIN,
    S_LVL_RD,
    S_FIN_RD,
    S_FIN_CAP,
    S_EMIT
  } bpdc_state_t;

endpackage

[src/bpdc_lerp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc_lerp
// Two-stage fixed-point lerp: a + floor((b - a) * t / 65536).
// ----------------------------------------------------------------------------
module bpdc_lerp
  import bpdc_pkg::*;
(
  input  logic           clk,
  input  coord_t         a,
  input  coord_t         b,
  input  logic [T_W-1:0] t,
  output coord_t         res
);

  localparam int PROD_W = COORD_W + T_W + 2;

  logic signed [COORD_W:0]   d_nxt;
  logic signed [COORD_W:0]   d1_r;
  coord_t                    a1_r;
  coord_t                    a2_r;
  logic signed [PROD_W-1:0]  prod;
  logic [COORD_W-1:0]        p2_r;

  assign d_nxt = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
  assign prod  = d1_r * $signed({1'b0, t});

  always_ff @(posedge clk) begin
    a1_r <= a;
    d1_r <= d_nxt;
    a2_r <= a1_r;
    p2_r <= prod[COORD_W+15:16];
  end

  assign res = a2_r + $signed(p2_r);

endmodule

[src/bpdc_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc_store
// Control point and work list memories, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module bpdc_store
  import bpdc_pkg::*;
(
  input  logic          clk,
  input  bpdc_mem_ctl_t ctl,
  input  coord_t        ctrl_wx,
  input  coord_t        ctrl_wy,
  input  coord_t        work_wx,
  input  coord_t        work_wy,
  output coord_t        ctrl_rx,
  output coord_t        ctrl_ry,
  output coord_t        work_rx,
  output coord_t        work_ry
);

  coord_t ctrl_x_mem [MAX_POINTS];
  coord_t ctrl_y_mem [MAX_POINTS];
  coord_t work_x_mem [MAX_POINTS];
  coord_t work_y_mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (ctl.ctrl_we) begin
      ctrl_x_mem[ctl.ctrl_waddr] <= ctrl_wx;
      ctrl_y_mem[ctl.ctrl_waddr] <= ctrl_wy;
    end
    ctrl_rx <= ctrl_x_mem[ctl.ctrl_raddr];
    ctrl_ry <= ctrl_y_mem[ctl.ctrl_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.work_we) begin
      work_x_mem[ctl.work_waddr] <= work_wx;
      work_y_mem[ctl.work_waddr] <= work_wy;
    end
    work_rx <= work_x_mem[ctl.work_raddr];
    work_ry <= work_y_mem[ctl.work_raddr];
  end

endmodule

[src/bezier_point_de_casteljau_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_point_de_casteljau_core
// Stores up to MAX_POINTS control points and evaluates the Bezier curve at t
// by de Casteljau reduction on one lerp unit per axis.
//
//   port group   dir   handshake            word
//   in_          in    in_valid/in_stall    bpdc_in_t (command, point, t)
//   out_         out   out_valid/out_stall  bpdc_out_t (curve point, status)
//
// Clear and append with room complete in S_IDLE; a dropped append or an empty
// evaluate passes through S_EMIT. Evaluate copies the points to the work
// list, then reduces them level by level, waiting for the lerp pipeline to
// drain between reduction levels.
// in_stall is high from acceptance until the result enters the output
// register; one result may wait there under out_stall while a new word is
// taken. Reset is synchronous; the point list is empty after reset.
// ----------------------------------------------------------------------------
module bezier_point_de_casteljau_core
  import bpdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bpdc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output bpdc_out_t out_data
);

  bpdc_state_t    state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  idx_t           level_r, level_nxt;
  idx_t           rd_idx_r, rd_idx_nxt;
  logic [T_W-1:0] t_r, t_nxt;
  bpdc_out_t      res_r, res_nxt;
  bpdc_out_t      out_r, out_nxt;
  logic           out_vld_r, out_vld_nxt;
  logic           rd_vld_r, rd_vld_nxt;
  logic           rd_cp_r, rd_cp_nxt;
  idx_t           rd_tag_r, rd_tag_nxt;
  logic           s1_vld_r, s1_vld_nxt;
  idx_t           s1_idx_r, s1_idx_nxt;
  logic           s2_vld_r;
  idx_t           s2_idx_r;
  coord_t         ax_r, ax_nxt;
  coord_t         ay_r, ay_nxt;

  bpdc_mem_ctl_t  mc;
  coord_t         ctrl_rx, ctrl_ry, work_rx, work_ry;
  coord_t         work_wx, work_wy;
  coord_t         lx_res, ly_res;
  idx_t           last_idx;

  assign last_idx = IDX_W'(cnt_r - CNT_W'(1));

  bpdc_store u_store (
    .clk     (clk),
    .ctl     (mc),
    .ctrl_wx (in_data.point_x),
    .ctrl_wy (in_data.point_y),
    .work_wx (work_wx),
    .work_wy (work_wy),
    .ctrl_rx (ctrl_rx),
    .ctrl_ry (ctrl_ry),
    .work_rx (work_rx),
    .work_ry (work_ry)
  );

  bpdc_lerp u_lerp_x (
    .clk (clk),
    .a   (ax_r),
    .b   (work_rx),
    .t   (t_r),
    .res (lx_res)
  );

  bpdc_lerp u_lerp_y (
    .clk (clk),
    .a   (ay_r),
    .b   (work_ry),
    .t   (t_r),
    .res (ly_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
      rd_vld_r  <= rd_vld_nxt;
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    level_r  <= level_nxt;
    rd_idx_r <= rd_idx_nxt;
    t_r      <= t_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
    rd_cp_r  <= rd_cp_nxt;
    rd_tag_r <= rd_tag_nxt;
    s1_idx_r <= s1_idx_nxt;
    s2_idx_r <= s1_idx_r;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    level_nxt   = level_r;
    rd_idx_nxt  = rd_idx_r;
    t_nxt       = t_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    rd_vld_nxt  = 1'b0;
    rd_cp_nxt   = rd_cp_r;
    rd_tag_nxt  = rd_idx_r;
    s1_vld_nxt  = 1'b0;
    s1_idx_nxt  = rd_tag_r - idx_t'(1);
    ax_nxt      = ax_r;
    ay_nxt      = ay_r;
    work_wx     = ctrl_rx;
    work_wy     = ctrl_ry;

    mc.ctrl_we    = 1'b0;
    mc.ctrl_waddr = cnt_r[IDX_W-1:0];
    mc.ctrl_raddr = rd_idx_r;
    mc.work_we    = 1'b0;
    mc.work_waddr = rd_tag_r;
    mc.work_raddr = rd_idx_r;

    in_stall = (state_r != S_IDLE);

    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end

    // read return: copy into work list, or feed the lerp pipe
    if (rd_vld_r) begin
      if (rd_cp_r) begin
        mc.work_we = 1'b1;
      end else begin
        ax_nxt = work_rx;
        ay_nxt = work_ry;
        if (rd_tag_r != '0) begin
          s1_vld_nxt = 1'b1;
        end
      end
    end

    if (s2_vld_r) begin
      mc.work_we    = 1'b1;
      mc.work_waddr = s2_idx_r;
      work_wx       = lx_res;
      work_wy       = ly_res;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.command)
            CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            CMD_APPEND: begin
              if (cnt_r == CNT_W'(MAX_POINTS)) begin
                res_nxt.curve_x = '0;
                res_nxt.curve_y = '0;
                res_nxt.status  = ST_FULL;
                state_nxt       = S_EMIT;
              end else begin
                mc.ctrl_we = 1'b1;
                cnt_nxt    = cnt_r + CNT_W'(1);
              end
            end
            CMD_EVAL: begin
              t_nxt = (in_data.t_param > T_ONE) ? T_ONE : in_data.t_param;
              if (cnt_r == '0) begin
                res_nxt.curve_x = '0;
                res_nxt.curve_y = '0;
                res_nxt.status  = ST_EMPTY;
                state_nxt       = S_EMIT;
              end else begin
                level_nxt  = last_idx;
                rd_idx_nxt = '0;
                state_nxt  = S_COPY;
              end
            end
            default: ;
          endcase
        end
      end
      S_COPY: begin
        rd_vld_nxt = 1'b1;
        rd_cp_nxt  = 1'b1;
        if (rd_idx_r == last_idx) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + idx_t'(1);
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !s1_vld_r && !s2_vld_r) begin
          rd_idx_nxt = '0;
          state_nxt  = (level_r == '0) ? S_FIN_RD : S_LVL_RD;
        end
      end
      S_LVL_RD: begin
        rd_vld_nxt = 1'b1;
        rd_cp_nxt  = 1'b0;
        if (rd_idx_r == level_r) begin
          level_nxt = level_r - idx_t'(1);
          state_nxt = S_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + idx_t'(1);
        end
      end
      S_FIN_RD: begin
        mc.work_raddr = '0;
        state_nxt     = S_FIN_CAP;
      end
      S_FIN_CAP: begin
        res_nxt.curve_x = work_rx;
        res_nxt.curve_y = work_ry;
        res_nxt.status  = ST_OK;
        state_nxt       = S_EMIT;
      end
      S_EMIT: begin
        if (!out_vld_r || !out_stall) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[tb/tb_bezier_point_de_casteljau_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bezier_point_de_casteljau_core
// Self-checking bench for the de Casteljau Bezier point evaluator. A queue of
// command words (directed corner cases, then random point lists with
// evaluations and noise) feeds a clocked driver. The driver predicts the
// result of every accepted word. A clocked monitor compares each returned
// word field by field. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_bezier_point_de_casteljau_core;
  import bpdc_pkg::*;

  localparam int RANDOM_WORDS = 500;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  bpdc_in_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  bpdc_out_t out_data;

  bezier_point_de_casteljau_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  bpdc_in_t    stim_q[$];
  bpdc_out_t   curve_q[$];
  bpdc_out_t   curve_head;
  coord_t      pts_x[MAX_POINTS];
  coord_t      pts_y[MAX_POINTS];
  int unsigned pts_n       = 0;
  int          n_total     = 0;
  int          n_accepted  = 0;
  int          errors      = 0;
  int          in_gap      = 0;
  int          out_hold    = 0;
  int          idle_cycles = 0;
  bit          in_quiet    = 1'b0;
  bit          out_quiet   = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // a + floor((b - a) * t / 2^16)
  function automatic coord_t lerp_q16(coord_t a, coord_t b, logic [T_W-1:0] t);
    longint d;
    longint p;
    d = longint'(b) - longint'(a);
    p = d * longint'(t);
    return coord_t'(longint'(a) + (p >>> 16));
  endfunction

  task automatic predict_word(input bpdc_in_t w);
    bpdc_out_t       r;
    coord_t          wx[MAX_POINTS];
    coord_t          wy[MAX_POINTS];
    logic [T_W-1:0]  t;
    int              lvl;
    int              i;
    r = '0;
    case (w.command)
      CMD_CLEAR: begin
        pts_n = 0;
      end
      CMD_APPEND: begin
        if (pts_n >= MAX_POINTS) begin
          r.status = ST_FULL;
          curve_q.insert(curve_q.size(), r);
        end else begin
          pts_x[pts_n] = w.point_x;
          pts_y[pts_n] = w.point_y;
          pts_n++;
        end
      end
      CMD_EVAL: begin
        if (pts_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          t = (w.t_param > T_ONE) ? T_ONE : w.t_param;
          for (i = 0; i < pts_n; i++) begin
            wx[i] = pts_x[i];
            wy[i] = pts_y[i];
          end
          for (lvl = pts_n - 1; lvl > 0; lvl--) begin
            for (i = 0; i < lvl; i++) begin
              wx[i] = lerp_q16(wx[i], wx[i+1], t);
              wy[i] = lerp_q16(wy[i], wy[i+1], t);
            end
          end
          r.curve_x = wx[0];
          r.curve_y = wy[0];
          r.status  = ST_OK;
        end
        curve_q.insert(curve_q.size(), r);
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 32'sh7fffffff;
    if (r < 16) return 32'sh80000000;
    if (r < 20) return '0;
    if (r < 50) return coord_t'($signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000);
    return coord_t'($urandom);
  endfunction

  function automatic logic [T_W-1:0] rand_t();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 16) return T_ONE;
    if (r < 30) return T_W'($urandom_range(65537, 131071));
    return T_W'($urandom_range(0, 65536));
  endfunction

  task automatic push_word(input logic [1:0] cmd, input coord_t x, input coord_t y,
                           input logic [T_W-1:0] t);
    bpdc_in_t w;
    w.command = cmd;
    w.point_x = x;
    w.point_y = y;
    w.t_param = t;
    stim_q.insert(stim_q.size(), w);
  endtask

  // stimulus and end of run
  initial begin
    int i;
    int k;
    int r;
    int target;
    // directed corners
    push_word(CMD_EVAL, rand_coord(), rand_coord(), rand_t());
    push_word(CMD_IGNORE, coord_t'($urandom), coord_t'($urandom), T_W'($urandom));
    push_word(CMD_APPEND, 32'sh7fffffff, 32'sh80000000, T_W'($urandom));
    push_word(CMD_EVAL, coord_t'($urandom), coord_t'($urandom), '0);
    push_word(CMD_APPEND, 32'sh80000000, 32'sh7fffffff, T_W'($urandom));
    push_word(CMD_EVAL, '0, '0, '0);
    push_word(CMD_EVAL, '0, '0, T_ONE);
    push_word(CMD_EVAL, '0, '0, T_W'(131071));
    push_word(CMD_EVAL, '0, '0, T_W'(32768));
    push_word(CMD_CLEAR, coord_t'($urandom), coord_t'($urandom), T_W'($urandom));
    push_word(CMD_EVAL, '0, '0, T_W'(1));
    for (i = 0; i < MAX_POINTS; i++) begin
      push_word(CMD_APPEND, i[0] ? 32'sh80000000 : 32'sh7fffffff,
                i[0] ? 32'sh7fffffff : 32'sh80000000, T_W'($urandom));
    end
    push_word(CMD_APPEND, 32'sh12345678, -32'sh1234567, '0);
    push_word(CMD_EVAL, '0, '0, T_W'(65535));

    // random point lists, evaluations and noise
    target = stim_q.size() + RANDOM_WORDS;
    while (stim_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        if ($urandom_range(0, 3) != 0)
          push_word(CMD_CLEAR, rand_coord(), rand_coord(), T_W'($urandom));
        r = $urandom_range(0, 99);
        if (r < 70)      k = $urandom_range(1, 5);
        else if (r < 90) k = $urandom_range(6, 12);
        else             k = $urandom_range(14, 18);
        for (i = 0; i < k; i++)
          push_word(CMD_APPEND, rand_coord(), rand_coord(), T_W'($urandom));
        k = $urandom_range(1, 4);
        for (i = 0; i < k; i++)
          push_word(CMD_EVAL, coord_t'($urandom), coord_t'($urandom), rand_t());
      end else if (r < 90) begin
        push_word(CMD_IGNORE, coord_t'($urandom), coord_t'($urandom), T_W'($urandom));
      end else if (r < 95) begin
        push_word(CMD_CLEAR, coord_t'($urandom), coord_t'($urandom), T_W'($urandom));
        push_word(CMD_EVAL, coord_t'($urandom), coord_t'($urandom), rand_t());
      end else begin
        push_word(CMD_APPEND, rand_coord(), rand_coord(), T_W'($urandom));
      end
    end
    n_total = stim_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total) @(posedge clk);
    while (curve_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_word(in_data);
        n_accepted++;
        if ($urandom_range(0, 63) == 0) in_quiet = !in_quiet;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (stim_q.size() != 0) begin
          in_data  <= stim_q.pop_front();
          in_valid <= 1'b1;
          in_gap   <= pick_gap(in_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (curve_q.size() == 0) begin
          $error("unexpected word: curve_x %0d curve_y %0d status %0d",
                 out_data.curve_x, out_data.curve_y, out_data.status);
          errors++;
        end else begin
          curve_head = curve_q.pop_front();
          if (out_data.curve_x !== curve_head.curve_x) begin
            $error("curve_x expected %0d got %0d", curve_head.curve_x, out_data.curve_x);
            errors++;
          end
          if (out_data.curve_y !== curve_head.curve_y) begin
            $error("curve_y expected %0d got %0d", curve_head.curve_y, out_data.curve_y);
            errors++;
          end
          if (out_data.status !== curve_head.status) begin
            $error("status expected %0d got %0d", curve_head.status, out_data.status);
            errors++;
          end
        end
        if ($urandom_range(0, 31) == 0) out_quiet = !out_quiet;
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold  <= out_hold - 1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) out_hold <= pick_gap(out_quiet);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

[bezier_point_de_casteljau_core.f]
src/bpdc_pkg.sv
src/bpdc_lerp.sv
src/bpdc_store.sv
src/bezier_point_de_casteljau_core.sv
tb/tb_bezier_point_de_casteljau_core.sv
